### src/midi_to_usb_event_parser_defines.svh
// Assertion macros shared by the MIDI to USB-MIDI event parser RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MIDI_TO_USB_EVENT_PARSER_DEFINES_SVH
`define MIDI_TO_USB_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define M2U_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m2u assertion failed");

// Next-cycle implication, checked outside reset.
`define M2U_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m2u assertion failed");

`endif

### src/m2u_pkg.sv
// Types and constants of the MIDI to USB-MIDI event parser.
// No dependencies; used by m2u_core and the top level.
`default_nettype none

package m2u_pkg;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_DONE = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  // MIDI status bytes.
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_UNDEF_F9 = 8'hF9;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONT     = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_UNDEF_FD = 8'hFD;
  localparam logic [7:0] ST_SENSE    = 8'hFE;
  localparam logic [7:0] ST_RESET    = 8'hFF;

  // Status high nibbles.
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;

  // USB-MIDI code index numbers.
  localparam logic [3:0] CIN_2BYTE_COMMON = 4'h2;
  localparam logic [3:0] CIN_3BYTE_COMMON = 4'h3;
  localparam logic [3:0] CIN_1BYTE_COMMON = 4'h5;
  localparam logic [3:0] CIN_SYSEX        = 4'h7;
  localparam logic [3:0] CIN_NOTE_OFF     = 4'h8;
  localparam logic [3:0] CIN_SINGLE_BYTE  = 4'hF;

  localparam logic [31:0] SYSEX_ID_FLAG     = 32'h8000_0000;
  localparam logic [31:0] SENSE_SLACK       = 32'd4;
  localparam logic [31:0] SENSE_TIMEOUT_RST = 32'd1000;

  typedef struct packed {
    func_t       func;
    logic        cable;
    logic [7:0]  midi_byte;
    logic [31:0] now;
    logic [5:0]  sysex_index;
  } item_t;

  typedef struct packed {
    logic        event_valid;
    logic        event_cable;
    logic [3:0]  code_index;
    logic [7:0]  midi0;
    logic [7:0]  midi1;
    logic [7:0]  midi2;
    logic [31:0] stamp;
    logic        sense_lost;
    logic        sysex_rd;   // sysex_data comes from the store
  } result_t;

  typedef struct packed {
    logic [31:0] last_time;
    logic [7:0]  running_status;
    logic [3:0]  code_index_cur;
    logic [6:0]  first_data;
    logic [1:0]  bytes_expected;
    logic [6:0]  bytes_count;
    logic        sense_flag;
    logic [31:0] sysex_id;
  } cable_state_t;

endpackage

`default_nettype wire

### src/m2u_sysex_mem.sv
// Sysex byte store: one write port, one registered read port.
// No dependencies.
`default_nettype none

module m2u_sysex_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/m2u_core.sv
// Per-cable MIDI receive state and the decode of one item into one result.
// Depends on m2u_pkg; drives the sysex store write and read ports.
`default_nettype none

module m2u_core #(
  parameter int SYSEX_DEPTH = 64,
  parameter int AW          = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire m2u_pkg::item_t   item,
  input  wire logic [31:0]      sense_timeout,
  output m2u_pkg::result_t      res,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_addr,
  output logic [7:0]            mem_wdata
);

  m2u_pkg::cable_state_t st_r   [2];
  m2u_pkg::cable_state_t st_nxt [2];
  m2u_pkg::cable_state_t cur;

  logic [6:0]  cnt_inc;
  logic [7:0]  sb;
  logic [3:0]  cin;
  logic [31:0] age0;
  logic [31:0] age1;
  logic        lost0;
  logic        lost1;
  logic        we_c;
  logic        re_c;
  logic [6:0]  offset;
  logic [7:0]  addr_full;

  function automatic m2u_pkg::cable_state_t clear_rx(input m2u_pkg::cable_state_t s);
    m2u_pkg::cable_state_t r;
    r = s;
    r.code_index_cur = 4'd0;
    r.running_status = 8'd0;
    r.bytes_expected = 2'd0;
    r.bytes_count    = 7'd0;
    return r;
  endfunction

  function automatic m2u_pkg::cable_state_t expect_msg(input m2u_pkg::cable_state_t s,
                                                       input logic [3:0] c,
                                                       input logic [7:0] status,
                                                       input logic [1:0] n);
    m2u_pkg::cable_state_t r;
    r = s;
    r.code_index_cur = c;
    r.running_status = status;
    r.bytes_expected = n;
    r.bytes_count    = 7'd0;
    return r;
  endfunction

  assign age0  = item.now - st_r[0].last_time + m2u_pkg::SENSE_SLACK;
  assign age1  = item.now - st_r[1].last_time + m2u_pkg::SENSE_SLACK;
  assign lost0 = st_r[0].sense_flag && (age0 > sense_timeout);
  assign lost1 = st_r[1].sense_flag && (age1 > sense_timeout);

  always_comb begin
    st_nxt  = st_r;
    res     = '0;
    we_c    = 1'b0;
    re_c    = 1'b0;
    offset  = {1'b0, item.sysex_index};
    cur     = st_r[item.cable];
    cnt_inc = cur.bytes_count + 7'd1;
    sb      = cur.running_status;
    cin     = cur.code_index_cur;

    unique case (item.func)
      m2u_pkg::FUNC_BYTE: begin
        cur.last_time = item.now;
        if (item.midi_byte[7]) begin
          cur.sense_flag = 1'b1;
          unique case (item.midi_byte) inside
            m2u_pkg::ST_CLOCK, m2u_pkg::ST_START, m2u_pkg::ST_CONT,
            m2u_pkg::ST_STOP, m2u_pkg::ST_RESET: begin
              res.event_valid = 1'b1;
              res.event_cable = item.cable;
              res.code_index  = m2u_pkg::CIN_SINGLE_BYTE;
              res.midi0       = item.midi_byte;
              res.stamp       = item.now;
              if (item.midi_byte == m2u_pkg::ST_RESET) begin
                cur = clear_rx(cur);
              end
            end
            m2u_pkg::ST_SENSE, m2u_pkg::ST_UNDEF_F9, m2u_pkg::ST_UNDEF_FD: begin
            end
            m2u_pkg::ST_SYSEX: begin
              if (cur.sysex_id == 32'd0) begin
                cur.sysex_id = item.now | m2u_pkg::SYSEX_ID_FLAG;
                cur = expect_msg(cur, m2u_pkg::CIN_SYSEX, m2u_pkg::ST_SYSEX, 2'd2);
              end else begin
                cur = clear_rx(cur);
              end
            end
            m2u_pkg::ST_SONG_POS: begin
              cur = expect_msg(cur, m2u_pkg::CIN_3BYTE_COMMON, item.midi_byte, 2'd2);
            end
            m2u_pkg::ST_MTC, m2u_pkg::ST_SONG_SEL: begin
              cur = expect_msg(cur, m2u_pkg::CIN_2BYTE_COMMON, item.midi_byte, 2'd1);
            end
            m2u_pkg::ST_UNDEF_F4, m2u_pkg::ST_UNDEF_F5: begin
              cur = clear_rx(cur);
            end
            m2u_pkg::ST_TUNE: begin
              res.event_valid = 1'b1;
              res.event_cable = item.cable;
              res.code_index  = m2u_pkg::CIN_1BYTE_COMMON;
              res.midi0       = item.midi_byte;
              res.stamp       = item.now;
              cur = clear_rx(cur);
            end
            m2u_pkg::ST_EOX: begin
              if (cur.running_status == m2u_pkg::ST_SYSEX && cur.bytes_count != 7'd0) begin
                res.event_valid = 1'b1;
                res.event_cable = item.cable;
                res.code_index  = m2u_pkg::CIN_SYSEX;
                res.midi0       = m2u_pkg::ST_SYSEX;
                res.midi1       = {1'b0, cur.bytes_count};
                res.midi2       = m2u_pkg::ST_EOX;
                res.stamp       = cur.sysex_id;
              end
              cur = clear_rx(cur);
            end
            default: begin
              // Channel voice messages: program change and channel pressure
              // carry one data byte, the rest carry two.
              if (item.midi_byte[7:4] == m2u_pkg::HI_PROGRAM ||
                  item.midi_byte[7:4] == m2u_pkg::HI_PRESSURE) begin
                cur = expect_msg(cur, item.midi_byte[7:4], item.midi_byte, 2'd1);
              end else begin
                cur = expect_msg(cur, item.midi_byte[7:4], item.midi_byte, 2'd2);
              end
            end
          endcase
        end else if (cur.running_status == m2u_pkg::ST_SYSEX) begin
          if (cur.bytes_count >= 7'(SYSEX_DEPTH)) begin
            cur = clear_rx(cur);
          end else begin
            we_c            = 1'b1;
            offset          = cur.bytes_count;
            cur.bytes_count = cnt_inc;
          end
        end else if (cur.bytes_expected != 2'd0) begin
          if (cnt_inc != {5'd0, cur.bytes_expected}) begin
            cur.bytes_count = cnt_inc;
            cur.first_data  = item.midi_byte[6:0];
          end else begin
            // Note-on with velocity zero goes out as note-off.
            if (sb[7:4] == m2u_pkg::HI_NOTE_ON && item.midi_byte == 8'd0) begin
              cin   = m2u_pkg::CIN_NOTE_OFF;
              sb[4] = 1'b0;
            end
            res.event_valid = 1'b1;
            res.event_cable = item.cable;
            res.code_index  = cin;
            res.midi0       = sb;
            res.stamp       = item.now;
            if (cur.bytes_expected == 2'd2) begin
              res.midi1 = {1'b0, cur.first_data};
              res.midi2 = item.midi_byte;
            end else begin
              res.midi1 = item.midi_byte;
            end
            if (cur.code_index_cur == m2u_pkg::CIN_3BYTE_COMMON ||
                cur.code_index_cur == m2u_pkg::CIN_2BYTE_COMMON) begin
              cur = clear_rx(cur);
            end else begin
              cur.bytes_count = 7'd0;
            end
          end
        end
        st_nxt[item.cable] = cur;
      end
      m2u_pkg::FUNC_TICK: begin
        // Cable 0 first; cable 1 is looked at only when cable 0 has not timed out.
        if (lost0) begin
          st_nxt[0]            = clear_rx(st_r[0]);
          st_nxt[0].sense_flag = 1'b0;
          st_nxt[0].sysex_id   = 32'd0;
          res.sense_lost       = 1'b1;
        end else if (lost1) begin
          st_nxt[1]            = clear_rx(st_r[1]);
          st_nxt[1].sense_flag = 1'b0;
          st_nxt[1].sysex_id   = 32'd0;
          res.sense_lost       = 1'b1;
        end
      end
      m2u_pkg::FUNC_DONE: begin
        st_nxt[item.cable].sysex_id = 32'd0;
      end
      m2u_pkg::FUNC_READ: begin
        if ({1'b0, item.sysex_index} < 7'(SYSEX_DEPTH)) begin
          re_c         = 1'b1;
          res.sysex_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Each cable owns a window of SYSEX_DEPTH entries in the store.
  assign addr_full = {1'b0, offset} + (item.cable ? 8'(SYSEX_DEPTH) : 8'd0);
  assign mem_addr  = addr_full[AW-1:0];
  assign mem_wdata = item.midi_byte;
  assign mem_we    = step && we_c;
  assign mem_re    = step && re_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0] <= '0;
      st_r[1] <= '0;
    end else if (step) begin
      st_r[0] <= st_nxt[0];
      st_r[1] <= st_nxt[1];
    end
  end

endmodule

`default_nettype wire

### src/midi_to_usb_event_parser.sv
// Top level of the two-cable MIDI 1.0 to USB-MIDI event packet parser.
// Depends on m2u_pkg, m2u_core, m2u_sysex_mem and the assertion header.
`default_nettype none

// The parser takes one item per clock while out_tready does not hold it back,
// and gives exactly one result per item, in order. An item waits in the input
// register, where the per-cable receive state is read, decoded and written
// back, and its result is loaded into the output register once that register
// can take it. The sustained rate is one item per cycle, set by that
// read-modify-write of the cable state within the input stage and by the
// registered read of the sysex store. The input register and the output
// register are separate stages, so a new item is taken while a result still
// waits for out_tready; the input side stalls only once both stages are full.
// The sysex store holds 2 * SYSEX_DEPTH bytes, one window per cable, and needs
// no clearing after reset: a read of a never-written byte returns whatever
// the memory holds. The sense_timeout register is written through the cfg
// channel, which is always ready; write it only while the parser is idle.

`include "midi_to_usb_event_parser_defines.svh"

module midi_to_usb_event_parser #(
  parameter int SYSEX_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // midi_byte[7:0], now[39:8], sysex_index[45:40]
  input  wire logic [2:0]  in_tuser,   // func[1:0], cable[2]
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // event_cable[0], code_index[4:1], midi0[12:5],
                                       // midi1[20:13], midi2[28:21], stamp[60:29],
                                       // sysex_data[68:61]
  output logic [1:0]       out_tuser,  // event_valid[0], sense_lost[1]
  // Configuration: sense_timeout.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int STORE_DEPTH = 2 * SYSEX_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  m2u_pkg::item_t   s1_item_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  m2u_pkg::result_t out_res_r;
  m2u_pkg::result_t res;
  logic [31:0]      sense_timeout_r;
  logic             advance;
  logic             step;
  logic             in_xfer;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;

  // The output register can take a new result when it is empty or its
  // result is transferred in this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !advance);
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      sense_timeout_r <= m2u_pkg::SENSE_TIMEOUT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        sense_timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.func        <= m2u_pkg::func_t'(in_tuser[1:0]);
      s1_item_r.cable       <= in_tuser[2];
      s1_item_r.midi_byte   <= in_tdata[7:0];
      s1_item_r.now         <= in_tdata[39:8];
      s1_item_r.sysex_index <= in_tdata[45:40];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  m2u_core #(
    .SYSEX_DEPTH (SYSEX_DEPTH),
    .AW          (AW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (s1_item_r),
    .sense_timeout (sense_timeout_r),
    .res           (res),
    .mem_we        (mem_we),
    .mem_re        (mem_re),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata)
  );

  // The read data register loads at the same edge as the result register.
  m2u_sysex_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_sysex_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.sense_lost, out_res_r.event_valid};
  assign out_tdata  = {3'd0,
                       (out_res_r.sysex_rd ? mem_rdata : 8'd0),
                       out_res_r.stamp,
                       out_res_r.midi2,
                       out_res_r.midi1,
                       out_res_r.midi0,
                       out_res_r.code_index,
                       out_res_r.event_cable};

  // A result only appears after an item was waiting in the input stage.
  `M2U_ASSERT_IMP(a_result_from_item, $rose(out_valid_r), $past(s1_valid_r))
  // A stalled input stage keeps its item.
  `M2U_ASSERT_NXT(a_stall_keeps_item, s1_valid_r && !in_tready, s1_valid_r)
  // No result carries an event packet along with a lost-sense flag.
  `M2U_ASSERT_IMP(a_event_or_lost, out_valid_r,
                  !(out_res_r.event_valid && out_res_r.sense_lost))
  // A buffer read never comes with an event packet.
  `M2U_ASSERT_IMP(a_read_no_event, out_valid_r && out_res_r.event_valid,
                  !out_res_r.sysex_rd)

endmodule

`default_nettype wire

### tb/midi_to_usb_event_parser_checker.sv
// Scoreboard for the MIDI to USB-MIDI event parser: predicts one result per input transfer
// and compares every result transfer against it in order.
// Depends on m2u_pkg for the item codes, the MIDI status bytes and the code index numbers.

module midi_to_usb_event_parser_checker
  import m2u_pkg::*;
#(
  parameter int SYSEX_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [71:0]       out_tdata,
  input  logic [1:0]        out_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output logic              idle,
  output logic [1:0][6:0]   sysex_fill,
  output int                packets_seen,
  output int                lost_seen
);

  typedef struct packed {
    logic        event_valid;
    logic        event_cable;
    logic [3:0]  code_index;
    logic [7:0]  midi0;
    logic [7:0]  midi1;
    logic [7:0]  midi2;
    logic [31:0] stamp;
    logic        sense_lost;
    logic [7:0]  sysex_data;
  } packet_t;

  logic [31:0]  sense_timeout;
  cable_state_t rx [2];
  logic [7:0]   sysex_mem [2][SYSEX_DEPTH];
  // Number of leading buffer entries per cable that have been written since reset.
  logic [6:0]   fill [2];
  packet_t      expected_packets [$];

  function automatic void clear_rx(input bit c);
    rx[c].code_index_cur = '0;
    rx[c].running_status = '0;
    rx[c].bytes_expected = '0;
    rx[c].bytes_count    = '0;
  endfunction

  function automatic void await_data(input bit c, input logic [3:0] cin,
                                     input logic [7:0] sb, input logic [1:0] n);
    rx[c].code_index_cur = cin;
    rx[c].running_status = sb;
    rx[c].bytes_expected = n;
    rx[c].bytes_count    = '0;
  endfunction

  function automatic packet_t make_packet(input bit c, input logic [3:0] cin,
                                          input logic [7:0] m0, input logic [7:0] m1,
                                          input logic [7:0] m2, input logic [31:0] stamp);
    packet_t p;
    p             = '0;
    p.event_valid = 1'b1;
    p.event_cable = c;
    p.code_index  = cin;
    p.midi0       = m0;
    p.midi1       = m1;
    p.midi2       = m2;
    p.stamp       = stamp;
    return p;
  endfunction

  function automatic packet_t status_byte(input bit c, input logic [7:0] sb,
                                          input logic [31:0] now);
    packet_t p;
    p = '0;
    rx[c].sense_flag = 1'b1;
    case (sb)
      ST_CLOCK, ST_START, ST_CONT, ST_STOP:
        p = make_packet(c, CIN_SINGLE_BYTE, sb, 8'h00, 8'h00, rx[c].last_time);
      ST_RESET: begin
        p = make_packet(c, CIN_SINGLE_BYTE, sb, 8'h00, 8'h00, rx[c].last_time);
        clear_rx(c);
      end
      ST_SENSE, ST_UNDEF_F9, ST_UNDEF_FD: ;
      ST_SYSEX: begin
        // A locked buffer drops the whole message.
        if (rx[c].sysex_id == '0) begin
          rx[c].sysex_id = now | SYSEX_ID_FLAG;
          await_data(c, CIN_SYSEX, ST_SYSEX, 2'd2);
        end else begin
          clear_rx(c);
        end
      end
      ST_SONG_POS:          await_data(c, CIN_3BYTE_COMMON, sb, 2'd2);
      ST_MTC, ST_SONG_SEL:  await_data(c, CIN_2BYTE_COMMON, sb, 2'd1);
      ST_UNDEF_F4, ST_UNDEF_F5: clear_rx(c);
      ST_TUNE: begin
        p = make_packet(c, CIN_1BYTE_COMMON, sb, 8'h00, 8'h00, rx[c].last_time);
        clear_rx(c);
      end
      ST_EOX: begin
        if (rx[c].running_status == ST_SYSEX && rx[c].bytes_count != '0) begin
          p = make_packet(c, CIN_SYSEX, ST_SYSEX, {1'b0, rx[c].bytes_count}, ST_EOX,
                          rx[c].sysex_id);
        end
        clear_rx(c);
      end
      default: begin
        // Only channel voice statuses are left here.
        if (sb[7:4] == HI_PROGRAM || sb[7:4] == HI_PRESSURE) begin
          await_data(c, sb[7:4], sb, 2'd1);
        end else begin
          await_data(c, sb[7:4], sb, 2'd2);
        end
      end
    endcase
    return p;
  endfunction

  function automatic packet_t data_byte(input bit c, input logic [7:0] db);
    packet_t    p;
    logic [7:0] sb;
    logic [3:0] cin;
    p = '0;
    rx[c].bytes_count = rx[c].bytes_count + 7'd1;
    if (rx[c].bytes_count != {5'b0, rx[c].bytes_expected}) begin
      rx[c].first_data = db[6:0];
      return p;
    end
    sb  = rx[c].running_status;
    cin = rx[c].code_index_cur;
    // Note-on with zero velocity goes out as note-off.
    if (sb[7:4] == HI_NOTE_ON && db == 8'h00) begin
      cin   = CIN_NOTE_OFF;
      sb[4] = 1'b0;
    end
    if (rx[c].bytes_expected == 2'd2) begin
      p = make_packet(c, cin, sb, {1'b0, rx[c].first_data}, db, rx[c].last_time);
    end else begin
      p = make_packet(c, cin, sb, db, 8'h00, rx[c].last_time);
    end
    // System common messages have no running status.
    if (rx[c].code_index_cur == CIN_3BYTE_COMMON || rx[c].code_index_cur == CIN_2BYTE_COMMON) begin
      clear_rx(c);
    end else begin
      rx[c].bytes_count = '0;
    end
    return p;
  endfunction

  function automatic bit sense_expired(input bit c, input logic [31:0] now);
    logic [31:0] span;
    span = now - rx[c].last_time + SENSE_SLACK;
    if (rx[c].sense_flag && span > sense_timeout) begin
      clear_rx(c);
      rx[c].sense_flag = 1'b0;
      rx[c].sysex_id   = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic packet_t predict_packet(input func_t fn, input bit c, input logic [7:0] b,
                                             input logic [31:0] now, input logic [5:0] idx);
    packet_t p;
    p = '0;
    case (fn)
      FUNC_BYTE: begin
        rx[c].last_time = now;
        if (b[7]) begin
          p = status_byte(c, b, now);
        end else if (rx[c].running_status == ST_SYSEX) begin
          if (rx[c].bytes_count >= SYSEX_DEPTH) begin
            clear_rx(c);
          end else begin
            sysex_mem[c][rx[c].bytes_count] = b;
            rx[c].bytes_count = rx[c].bytes_count + 7'd1;
            if (rx[c].bytes_count > fill[c]) fill[c] = rx[c].bytes_count;
          end
        end else if (rx[c].bytes_expected != '0) begin
          p = data_byte(c, b);
        end
      end
      FUNC_TICK: begin
        // Cable 1 is only looked at when cable 0 did not time out.
        if (sense_expired(1'b0, now)) p.sense_lost = 1'b1;
        else if (sense_expired(1'b1, now)) p.sense_lost = 1'b1;
      end
      FUNC_DONE: rx[c].sysex_id = '0;
      default: begin
        if (idx < SYSEX_DEPTH) p.sysex_data = sysex_mem[c][idx];
      end
    endcase
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    packet_t want;
    if (!rst_n) begin
      sense_timeout = SENSE_TIMEOUT_RST;
      for (int c = 0; c < 2; c++) begin
        rx[c]   = '0;
        fill[c] = '0;
      end
      expected_packets.delete();
      fail_count   = 0;
      packets_seen = 0;
      lost_seen    = 0;
    end else begin
      if (cfg_valid && cfg_ready) sense_timeout = cfg_data;
      if (out_tvalid && out_tready) begin
        if (expected_packets.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, expected none, actual %h/%h",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_packets.pop_front();
          check_field("event_valid", want.event_valid, out_tuser[0]);
          check_field("event_cable", want.event_cable, out_tdata[0]);
          check_field("code_index",  want.code_index,  out_tdata[4:1]);
          check_field("midi0",       want.midi0,       out_tdata[12:5]);
          check_field("midi1",       want.midi1,       out_tdata[20:13]);
          check_field("midi2",       want.midi2,       out_tdata[28:21]);
          check_field("stamp",       want.stamp,       out_tdata[60:29]);
          check_field("sense_lost",  want.sense_lost,  out_tuser[1]);
          check_field("sysex_data",  want.sysex_data,  out_tdata[68:61]);
          if (want.event_valid) packets_seen++;
          if (want.sense_lost) lost_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_packets.push_back(predict_packet(func_t'(in_tuser[1:0]), in_tuser[2],
                                                  in_tdata[7:0], in_tdata[39:8],
                                                  in_tdata[45:40]));
      end
    end
    idle       <= (expected_packets.size() == 0);
    sysex_fill <= {fill[1], fill[0]};
  end

endmodule

### tb/midi_to_usb_event_parser_tb.sv
// Top of the testbench for the MIDI to USB-MIDI event parser: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict. Depends on m2u_pkg, the parser RTL and
// midi_to_usb_event_parser_checker, which does all prediction and comparison.

module midi_to_usb_event_parser_tb;
  import m2u_pkg::*;

  localparam int SYSEX_DEPTH       = 64;
  // Longest quiet stretch a correct run can show is the receiver hold-off below plus a
  // sender gap; the limit leaves a wide margin above that.
  localparam int STALL_LIMIT       = 2000;
  localparam int HOLD_CYCLES       = 150;
  localparam int ITEMS_PER_SETTING = 115;
  localparam int N_SETTINGS        = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [47:0] in_tdata   = '0;    // midi_byte[7:0], now[39:8], sysex_index[45:40]
  logic [2:0]  in_tuser   = '0;    // func[1:0], cable[2]
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [31:0] cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;          // event_cable[0], code_index[4:1], midi0[12:5],
                                   // midi1[20:13], midi2[28:21], stamp[60:29],
                                   // sysex_data[68:61]
  logic [1:0]  out_tuser;          // event_valid[0], sense_lost[1]
  logic        cfg_ready;

  int              fail_count;
  logic            pred_idle;
  logic [1:0][6:0] sysex_fill;
  int              packets_seen;
  int              lost_seen;

  // Bookkeeping for the stimulus and the closing summary.
  logic [31:0] uptime      = '0;
  int          burst_left  = 0;
  int          n_items     = 0;
  int          n_settings  = 0;
  int          n_sysex     = 0;
  int          n_ticks     = 0;
  int          n_reads     = 0;
  bit          random_on   = 1'b0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  midi_to_usb_event_parser #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  midi_to_usb_event_parser_checker #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .idle         (pred_idle),
    .sysex_fill   (sysex_fill),
    .packets_seen (packets_seen),
    .lost_seen    (lost_seen)
  );

  // Watchdog: any transfer on any channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("midi_to_usb_event_parser_tb failed");
      $finish;
    end
  end

  // Receiver. It changes its stall pattern after each segment of random length: always
  // ready, a coin toss per cycle, or an occasional stall. Once the random stimulus has
  // started it holds out_tready low for a long stretch, so that both pipeline stages
  // fill and the parser has to drop in_tready while the sender keeps offering.
  initial begin
    int  seg;
    int  mode;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (random_on && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(4, 60);
      repeat (seg) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Uptime moves forward by a few ticks per item, now and then jumps ahead far enough to
  // trip the sense timeout, and rarely lands anywhere in the 32-bit range.
  function automatic logic [31:0] step_time();
    uptime = uptime + 32'($urandom_range(0, 24));
    if ($urandom_range(0, 63) == 0) uptime = uptime + 32'($urandom_range(0, 3000));
    if ($urandom_range(0, 255) == 0) uptime = $urandom;
    return uptime;
  endfunction

  // One input transfer. The sender works in bursts: when a burst is used up it drops
  // in_tvalid for a random gap (sometimes none) and starts a new burst. Called at a
  // rising edge, it returns at the edge where the item was taken.
  task automatic send_item(input func_t fn, input bit c, input logic [7:0] b,
                           input logic [31:0] now, input logic [5:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, now, b};
    in_tuser  <= {c, fn};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    burst_left--;
    n_items++;
  endtask

  task automatic send_byte(input bit c, input logic [7:0] b);
    send_item(FUNC_BYTE, c, b, step_time(), 6'($urandom));
  endtask

  // The cable field of a tick is ignored by the parser, so it is random like the rest.
  task automatic send_tick();
    send_item(FUNC_TICK, 1'($urandom), 8'($urandom), step_time(), 6'($urandom));
    n_ticks++;
  endtask

  // Reads stay inside the part of the buffer that has been written. The fill level seen
  // here may lag the parser by one item, which only makes the choice more cautious.
  task automatic read_buffer(input bit c);
    if (sysex_fill[c] == '0) begin
      send_tick();
    end else begin
      send_item(FUNC_READ, c, 8'($urandom), step_time(),
                6'($urandom_range(0, int'(sysex_fill[c]) - 1)));
      n_reads++;
    end
  endtask

  function automatic logic [7:0] pick_realtime();
    case ($urandom_range(0, 6))
      0:       return ST_CLOCK;
      1:       return ST_UNDEF_F9;
      2:       return ST_START;
      3:       return ST_CONT;
      4:       return ST_STOP;
      5:       return ST_UNDEF_FD;
      default: return ST_SENSE;
    endcase
  endfunction

  // Any channel voice status: high nibble 8 through E, random channel.
  function automatic logic [7:0] pick_channel_status();
    return {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
  endfunction

  // One random piece of traffic. Most of it is well-formed MIDI with random content,
  // with real-time bytes slipped in between; the rest is broken or plain noise.
  task automatic random_message();
    int         kind;
    int         n;
    int         len;
    bit         c;
    logic [7:0] sb;
    kind = $urandom_range(0, 99);
    c    = 1'($urandom);
    if (kind < 30) begin
      // Channel message, repeated up to three more times under running status.
      sb = pick_channel_status();
      n  = (sb[7:4] == HI_PROGRAM || sb[7:4] == HI_PRESSURE) ? 1 : 2;
      send_byte(c, sb);
      repeat ($urandom_range(1, 4)) begin
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) send_byte(c, pick_realtime());
          if (k == n - 1 && sb[7:4] == HI_NOTE_ON && $urandom_range(0, 2) == 0) begin
            send_byte(c, 8'h00);
          end else begin
            send_byte(c, {1'b0, 7'($urandom)});
          end
        end
      end
    end else if (kind < 40) begin
      // System common: song position, song select or time code, tune request.
      case ($urandom_range(0, 3))
        0: begin
          send_byte(c, ST_SONG_POS);
          send_byte(c, {1'b0, 7'($urandom)});
          send_byte(c, {1'b0, 7'($urandom)});
        end
        1: begin
          send_byte(c, ST_SONG_SEL);
          send_byte(c, {1'b0, 7'($urandom)});
        end
        2: begin
          send_byte(c, ST_MTC);
          send_byte(c, {1'b0, 7'($urandom)});
        end
        default: send_byte(c, ST_TUNE);
      endcase
      // An extra data byte after a finished common message has no status to go with.
      if ($urandom_range(0, 3) == 0) send_byte(c, {1'b0, 7'($urandom)});
    end else if (kind < 60) begin
      // Sysex: mostly short, sometimes empty, exactly full, or overflowing.
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = SYSEX_DEPTH;
        2:       len = $urandom_range(SYSEX_DEPTH + 1, SYSEX_DEPTH + 6);
        default: len = $urandom_range(1, 12);
      endcase
      send_byte(c, ST_SYSEX);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 11) == 0) send_byte(c, pick_realtime());
        send_byte(c, {1'b0, 7'($urandom)});
      end
      if ($urandom_range(0, 9) != 0) send_byte(c, ST_EOX);
      else send_byte(c, pick_channel_status());
      repeat ($urandom_range(0, 3)) read_buffer(c);
      if ($urandom_range(0, 4) != 0) begin
        send_item(FUNC_DONE, c, 8'($urandom), step_time(), 6'($urandom));
      end
      n_sysex++;
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 3)) send_tick();
    end else if (kind < 80) begin
      read_buffer(c);
      if ($urandom_range(0, 1) == 0) begin
        send_item(FUNC_DONE, c, 8'($urandom), step_time(), 6'($urandom));
      end
    end else if (kind < 88) begin
      // Noise: any byte value or a stray release on either cable.
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(FUNC_DONE, 1'($urandom), 8'($urandom), step_time(), 6'($urandom));
        end else begin
          send_byte(1'($urandom), 8'($urandom));
        end
      end
    end else if (kind < 94) begin
      // Statuses that wipe the receive state.
      case ($urandom_range(0, 2))
        0:       send_byte(c, ST_RESET);
        1:       send_byte(c, ST_UNDEF_F4);
        default: send_byte(c, ST_UNDEF_F5);
      endcase
      send_byte(c, {1'b0, 7'($urandom)});
    end else begin
      // A message cut short by another status.
      send_byte(c, ($urandom_range(0, 1) == 0) ? ST_SONG_POS : pick_channel_status());
      send_byte(c, {1'b0, 7'($urandom)});
      send_byte(c, pick_channel_status());
      send_byte(c, {1'b0, 7'($urandom)});
    end
  endtask

  // Lowers in_tvalid and waits until every predicted result has come back, then idles
  // on to cover the two pipeline stages. The first edge lets the scoreboard see the
  // last item taken before its idle flag is trusted.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!pred_idle) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [31:0] timeouts [N_SETTINGS];
    int          start_items;
    // Timeout settings for the random phases: both extremes, short ones that make ticks
    // fire often, a random one, and the reset value.
    timeouts[0] = 32'd1;
    timeouts[1] = 32'hFFFF_FFFF;
    timeouts[2] = 32'd40;
    timeouts[3] = 32'd300;
    timeouts[4] = 32'($urandom_range(50, 5000));
    timeouts[5] = SENSE_TIMEOUT_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the reset timeout.
    // A tick before any status byte finds nothing to time out; uptime zero.
    send_item(FUNC_TICK, 1'b0, 8'h00, 32'd0, 6'd0);
    n_ticks++;
    // A data byte with no status is ignored.
    send_byte(1'b0, 8'h45);
    // Note-on, then the same status reused with zero velocity, which becomes note-off.
    send_byte(1'b0, {HI_NOTE_ON, 4'h0});
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h7F);
    send_byte(1'b0, 8'h3C);
    send_byte(1'b0, 8'h00);
    // Two-byte channel message on the other cable, top channel.
    send_byte(1'b1, {HI_PRESSURE, 4'hF});
    send_byte(1'b1, 8'h7F);
    // System common messages.
    send_byte(1'b0, ST_SONG_POS);
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, 8'h22);
    send_byte(1'b0, ST_MTC);
    send_byte(1'b0, 8'h05);
    send_byte(1'b0, ST_TUNE);
    // Clock is passed on; the undefined real-time byte and active sense are dropped.
    send_byte(1'b0, ST_CLOCK);
    send_byte(1'b0, ST_UNDEF_F9);
    send_byte(1'b0, ST_SENSE);
    // Two-byte sysex, its length packet and a read back, then a second start while the
    // buffer is still locked, which is dropped, then the release.
    send_byte(1'b1, ST_SYSEX);
    send_byte(1'b1, 8'h7F);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, ST_EOX);
    send_item(FUNC_READ, 1'b1, 8'hFF, step_time(), 6'd1);
    n_reads++;
    send_byte(1'b1, ST_SYSEX);
    send_item(FUNC_DONE, 1'b1, 8'h00, step_time(), 6'd0);
    // F4 clears the receive state; system reset is passed on and clears it too.
    send_byte(1'b0, ST_UNDEF_F4);
    send_byte(1'b0, ST_RESET);
    // Tick at the top of the uptime range: cable 0 has gone quiet far too long.
    uptime = 32'hFFFF_FFFF;
    send_item(FUNC_TICK, 1'b1, 8'h00, uptime, 6'h3F);
    n_ticks++;
    wait_idle();

    // Random part, one phase per timeout setting, written only while the parser is idle.
    random_on = 1'b1;
    for (int phase = 0; phase < N_SETTINGS; phase++) begin
      write_timeout(timeouts[phase]);
      start_items = n_items;
      while (n_items - start_items < ITEMS_PER_SETTING) random_message();
      wait_idle();
    end
    repeat (8) @(posedge clk);

    $display("Ran %0d items under %0d sense_timeout settings: %0d sysex messages, %0d ticks,",
             n_items, n_settings, n_sysex, n_ticks);
    $display("%0d buffer reads; %0d event packets and %0d lost-signal flags were checked.",
             n_reads, packets_seen, lost_seen);
    if (fail_count == 0 && pred_idle) begin
      $display("midi_to_usb_event_parser_tb passed");
    end else begin
      $display("midi_to_usb_event_parser_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/m2u_pkg.sv
src/m2u_sysex_mem.sv
src/m2u_core.sv
src/midi_to_usb_event_parser.sv
tb/midi_to_usb_event_parser_checker.sv
tb/midi_to_usb_event_parser_tb.sv
